>>> hdl/rpt_pkg.sv
// rpt_pkg: types, codes and constants of the pull requester tracker
// no dependencies; used by rpt_step and rdma_pull_requester_tracker
package rpt_pkg;

    localparam int FRAME_BYTES      = 4096;
    localparam int FRAME_SHIFT      = 12;
    localparam int FRAMES_PER_BLOCK = 8;
    localparam int BLOCK_BYTES      = FRAME_BYTES * FRAMES_PER_BLOCK;
    localparam logic [31:0] MAGIC_XOR = 32'h2211_1867;
    localparam int MAGIC_SHIFT      = 13;

    // configuration register indexes
    localparam logic [2:0] CFG_XFER_LEN   = 3'd0;
    localparam logic [2:0] CFG_REMOTE_OFS = 3'd1;
    localparam logic [2:0] CFG_LOCAL_OFS  = 3'd2;
    localparam logic [2:0] CFG_EP_INDEX   = 3'd3;
    localparam logic [2:0] CFG_HANDLE_ID  = 3'd4;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REQUEST  = 3'd1,
        KIND_DROPPED  = 3'd2,
        KIND_DONE     = 3'd3,
        KIND_TRUNC    = 3'd4,
        KIND_REFUSED  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_SHORT     = 3'd1,
        CAUSE_MAGIC     = 3'd2,
        CAUSE_HANDLE    = 3'd3,
        CAUSE_OUTSIDE   = 3'd4,
        CAUSE_DUPLICATE = 3'd5
    } cause_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] reply_magic;
        logic [31:0] reply_handle;
        logic [31:0] reply_seqnum;
        logic [12:0] reply_length;
        logic [15:0] payload_length;
        logic [31:0] reply_msg_offset;
        logic        copy_ok;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        cause_t      drop_cause;
        logic [15:0] req_block_length;
        logic [11:0] req_pull_offset;
        logic [31:0] req_frame_index;
        logic [3:0]  req_frames;
        logic [31:0] copy_address;
        logic [31:0] pulled_len;
    } out_item_t;

    typedef struct packed {
        logic [31:0] xfer_len;
        logic [11:0] remote_ofs;
        logic [11:0] local_ofs;
        logic [7:0]  ep_index;
        logic [31:0] handle_id;
    } rpt_cfg_t;

    typedef struct packed {
        logic        active;
        logic [31:0] remaining;
        logic [31:0] first_frame;
        logic [3:0]  frame_count;
        logic [7:0]  pending;
    } rpt_state_t;

endpackage

>>> hdl/rpt_step.sv
// rpt_step: next transfer state and result word for one input word
// depends on rpt_pkg
module rpt_step (
    input  rpt_pkg::rpt_state_t st,
    input  rpt_pkg::rpt_cfg_t   cfg,
    input  rpt_pkg::in_item_t   item,
    output rpt_pkg::rpt_state_t st_next,
    output rpt_pkg::out_item_t  res
);
    import rpt_pkg::*;

    // block sizing, shared by the first and the later blocks
    logic        blk_first;
    logic [11:0] blk_poff;
    logic [16:0] blk_limit;
    logic [31:0] blk_rem;
    logic [16:0] blk_len;
    logic [16:0] blk_span;
    logic [17:0] blk_round;
    logic [3:0]  blk_frames;
    logic [7:0]  blk_mask;
    logic [31:0] blk_rem_after;

    // reply checks
    logic        chk_short;
    logic [18:0] chk_midx;
    logic        chk_magic;
    logic        chk_handle;
    logic [32:0] chk_rel;
    logic        chk_outside;
    logic [2:0]  chk_bit;
    logic        chk_dup;
    logic [7:0]  pend_after;
    logic [31:0] addr;
    logic [31:0] pulled;
    logic [31:0] next_first;

    assign blk_first = (item.cmd == CMD_START);
    assign blk_poff  = blk_first ? cfg.remote_ofs : 12'd0;
    assign blk_limit = 17'(BLOCK_BYTES) - {5'd0, blk_poff};
    assign blk_rem   = blk_first ? cfg.xfer_len : st.remaining;
    assign blk_len   = (blk_rem < {15'd0, blk_limit}) ? blk_rem[16:0] : blk_limit;
    assign blk_span  = {5'd0, blk_poff} + blk_len;
    assign blk_round = {1'b0, blk_span} + 18'(FRAME_BYTES - 1);
    assign blk_frames = blk_round[FRAME_SHIFT +: 4];
    assign blk_rem_after = blk_rem - {15'd0, blk_len};

    always_comb begin
        for (int i = 0; i < FRAMES_PER_BLOCK; i++) begin
            blk_mask[i] = (4'(i) < blk_frames);
        end
    end

    assign chk_short  = ({3'd0, item.reply_length} > item.payload_length);
    assign chk_midx   = 19'((item.reply_magic ^ MAGIC_XOR) >> MAGIC_SHIFT);
    assign chk_magic  = (chk_midx != {11'd0, cfg.ep_index});
    assign chk_handle = !st.active || (item.reply_handle != cfg.handle_id);
    // borrow bit flags a sequence number below the block
    assign chk_rel     = {1'b0, item.reply_seqnum} - {1'b0, st.first_frame};
    assign chk_outside = chk_rel[32] || (chk_rel[31:0] >= {28'd0, st.frame_count});
    assign chk_bit     = chk_rel[2:0];
    assign chk_dup     = !st.pending[chk_bit];
    assign pend_after  = st.pending & ~(8'd1 << chk_bit);
    assign addr        = item.reply_msg_offset + {20'd0, cfg.local_ofs};
    assign pulled      = cfg.xfer_len - st.remaining;
    assign next_first  = st.first_frame + {28'd0, st.frame_count};

    always_comb begin
        st_next = st;
        res = '{kind: KIND_DROPPED, drop_cause: CAUSE_NONE, default: '0};
        if (item.cmd == CMD_START) begin
            if (st.active) begin
                res.kind = KIND_REFUSED;
            end else if (blk_frames == 4'd0) begin
                // empty transfer completes at once
                st_next = '0;
                res.kind = KIND_DONE;
            end else begin
                st_next.active      = 1'b1;
                st_next.remaining   = blk_rem_after;
                st_next.first_frame = '0;
                st_next.frame_count = blk_frames;
                st_next.pending     = blk_mask;
                res.kind             = KIND_REQUEST;
                res.req_block_length = blk_len[15:0];
                res.req_pull_offset  = blk_poff;
                res.req_frame_index  = '0;
                res.req_frames       = blk_frames;
            end
        end else if (chk_short) begin
            res.drop_cause = CAUSE_SHORT;
        end else if (chk_magic) begin
            res.drop_cause = CAUSE_MAGIC;
        end else if (chk_handle) begin
            res.drop_cause = CAUSE_HANDLE;
        end else if (chk_outside) begin
            res.drop_cause = CAUSE_OUTSIDE;
        end else if (chk_dup) begin
            res.drop_cause = CAUSE_DUPLICATE;
        end else begin
            res.copy_address = addr;
            if (!item.copy_ok) begin
                st_next = '0;
                res.kind = KIND_TRUNC;
                res.pulled_len = pulled;
            end else if (pend_after != 8'd0) begin
                st_next.pending = pend_after;
                res.kind = KIND_ACCEPTED;
            end else if (st.remaining != 32'd0) begin
                st_next.remaining   = blk_rem_after;
                st_next.first_frame = next_first;
                st_next.frame_count = blk_frames;
                st_next.pending     = blk_mask;
                res.kind             = KIND_REQUEST;
                res.req_block_length = blk_len[15:0];
                res.req_pull_offset  = blk_poff;
                res.req_frame_index  = next_first;
                res.req_frames       = blk_frames;
            end else begin
                st_next = '0;
                res.kind = KIND_DONE;
                res.pulled_len = pulled;
            end
        end
    end

endmodule

>>> hdl/rdma_pull_requester_tracker.sv
// Requester side tracker of a remote-read pull transfer.
// Channels: s_* takes start and reply words, m_* gives one result word per
// input word, cfg_* writes the five transfer registers (index 0 total length,
// 1 remote offset, 2 local offset, 3 endpoint index, 4 handle id). Other
// indexes are ignored. cfg_ready is always high; write registers only while
// no word is in flight.
// Path: an accepted input word is held in the input register, then moves to
// the result register, which drives m_valid and m_item.
// Throughput: one word per cycle while m_ready is high. Transfer state is read
// and updated in the same cycle a word moves from input to result register.
// When m_ready is low the result register holds and the input register can
// still take one more word; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers, clears the
// transfer state and sets all configuration registers to zero.
// Depends on rpt_pkg and rpt_step.
module rdma_pull_requester_tracker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpt_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import rpt_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    rpt_state_t state_reg;
    rpt_state_t state_next;
    rpt_cfg_t   cfg_reg;
    out_item_t  res;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    rpt_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload words
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_XFER_LEN:   cfg_reg.xfer_len   <= cfg_data;
                CFG_REMOTE_OFS: cfg_reg.remote_ofs <= cfg_data[11:0];
                CFG_LOCAL_OFS:  cfg_reg.local_ofs  <= cfg_data[11:0];
                CFG_EP_INDEX:   cfg_reg.ep_index   <= cfg_data[7:0];
                CFG_HANDLE_ID:  cfg_reg.handle_id  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
